>>> sv/bresenham_line_pixel_generator_unit_macros.svh
// Assertion macros for the line pixel generator; blp_step uses them.
// Each macro expects clk_i, and BLP_ASSERT also rst_ni, to be visible where it is used.
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_UNIT_MACROS_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_UNIT_MACROS_SVH

// Checked at every rising edge outside reset.
`define BLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define BLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/blp_pkg.sv
// Types and constants of the line pixel generator.
// No dependencies; used by every module of the block.
package blp_pkg;

  localparam int PIXELS_PER_BYTE = 8;
  localparam int PIX_IDX_W       = $clog2(PIXELS_PER_BYTE);

  localparam int ADDR_W   = 16;
  localparam int BPR_W    = 8;
  localparam int SCREEN_W = 10;
  localparam int CMD_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_SET   = 8'hF8;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 8'hF0;

  localparam logic [ADDR_W-1:0]   RST_GRAPHICS_BASE = 16'd0;
  localparam logic [BPR_W-1:0]    RST_BYTES_PER_ROW = 8'd30;
  localparam logic [SCREEN_W-1:0] RST_SCREEN_WIDTH  = 10'd240;
  localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT = 10'd128;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAPHICS_BASE = 3'd0,
    CFG_BYTES_PER_ROW = 3'd1,
    CFG_SCREEN_WIDTH  = 3'd2,
    CFG_SCREEN_HEIGHT = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic line_pix;
    logic show;
    logic last;
  } pix_ctrl_t;

endpackage

>>> sv/blp_step.sv
// Input register and Bresenham step stage with the line state registers.
// Depends on blp_pkg and the assertion macro header.
`include "bresenham_line_pixel_generator_unit_macros.svh"

module blp_step #(
  parameter int COORD_BITS = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  blp_pkg::req_e                req_type_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic                         show_pixel_i,
  input  logic                         pix_ready_i,
  output logic                         pix_valid_o,
  output blp_pkg::pix_ctrl_t           pix_ctrl_o,
  output logic signed [COORD_BITS-1:0] pix_x_o,
  output logic signed [COORD_BITS-1:0] pix_y_o
);
  import blp_pkg::*;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int TWICE_W = COORD_BITS + 2;
  localparam int ERR_W   = COORD_BITS + 4;

  logic                         in_valid_q, in_valid_d;
  req_e                         req_q;
  logic signed [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
  logic                         show_q;

  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [TWICE_W-1:0]           tdx_q, tdx_d, tdy_q, tdy_d;
  logic signed [ERR_W-1:0]      err_q, err_d;
  logic                         dxn_q, dxn_d, dyn_q, dyn_d;
  logic                         xmaj_q, xmaj_d;
  logic                         show_line_q, show_line_d;
  logic                         line_active_q, line_active_d;

  logic                         pix_valid_q, pix_valid_d;
  pix_ctrl_t                    ctrl_q, ctrl_d;
  logic signed [COORD_BITS-1:0] pix_x_q, pix_y_q;

  logic                         pix_ready;
  logic                         fire;
  logic signed [DIFF_W-1:0]     dx, dy;
  logic [COORD_BITS-1:0]        adx, ady;
  logic [TWICE_W-1:0]           s_tdx, s_tdy;
  logic                         s_xmaj;
  logic signed [COORD_BITS-1:0] x_adv, y_adv;
  logic                         err_ge;
  logic                         step_last;

  assign pix_ready  = !pix_valid_q || pix_ready_i;
  assign in_ready_o = !in_valid_q || pix_ready;
  assign fire       = in_valid_q && pix_ready;
  assign in_valid_d = in_ready_o ? in_valid_i : in_valid_q;
  assign pix_valid_d = pix_ready ? in_valid_q : pix_valid_q;

  assign dx     = DIFF_W'(ex_q) - DIFF_W'(sx_q);
  assign dy     = DIFF_W'(ey_q) - DIFF_W'(sy_q);
  assign adx    = COORD_BITS'(dx[DIFF_W-1] ? -dx : dx);
  assign ady    = COORD_BITS'(dy[DIFF_W-1] ? -dy : dy);
  assign s_tdx  = {1'b0, adx, 1'b0};
  assign s_tdy  = {1'b0, ady, 1'b0};
  assign s_xmaj = s_tdx > s_tdy;

  assign x_adv  = cur_x_q + (dxn_q ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
  assign y_adv  = cur_y_q + (dyn_q ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
  assign err_ge = !err_q[ERR_W-1];

  always_comb begin
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    tgt_x_d       = tgt_x_q;
    tgt_y_d       = tgt_y_q;
    tdx_d         = tdx_q;
    tdy_d         = tdy_q;
    err_d         = err_q;
    dxn_d         = dxn_q;
    dyn_d         = dyn_q;
    xmaj_d        = xmaj_q;
    show_line_d   = show_line_q;
    line_active_d = line_active_q;
    step_last     = 1'b0;
    ctrl_d        = '0;
    if (req_q == REQ_START) begin
      cur_x_d     = sx_q;
      cur_y_d     = sy_q;
      tgt_x_d     = ex_q;
      tgt_y_d     = ey_q;
      tdx_d       = s_tdx;
      tdy_d       = s_tdy;
      dxn_d       = dx[DIFF_W-1];
      dyn_d       = dy[DIFF_W-1];
      xmaj_d      = s_xmaj;
      show_line_d = show_q;
      if (s_xmaj) begin
        err_d     = ERR_W'(s_tdy) - ERR_W'(adx);
        step_last = (sx_q == ex_q);
      end else begin
        err_d     = ERR_W'(s_tdx) - ERR_W'(ady);
        step_last = (sy_q == ey_q);
      end
      line_active_d = !step_last;
      ctrl_d        = '{line_pix: 1'b1, show: show_q, last: step_last};
    end else if (line_active_q) begin
      if (xmaj_q) begin
        cur_x_d = x_adv;
        if (err_ge) begin
          cur_y_d = y_adv;
          err_d   = err_q - ERR_W'(tdx_q) + ERR_W'(tdy_q);
        end else begin
          err_d   = err_q + ERR_W'(tdy_q);
        end
        step_last = (x_adv == tgt_x_q);
      end else begin
        cur_y_d = y_adv;
        if (err_ge) begin
          cur_x_d = x_adv;
          err_d   = err_q - ERR_W'(tdy_q) + ERR_W'(tdx_q);
        end else begin
          err_d   = err_q + ERR_W'(tdx_q);
        end
        step_last = (y_adv == tgt_y_q);
      end
      line_active_d = !step_last;
      ctrl_d        = '{line_pix: 1'b1, show: show_line_q, last: step_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      pix_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      pix_valid_q <= pix_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q  <= req_type_i;
      sx_q   <= start_x_i;
      sy_q   <= start_y_i;
      ex_q   <= end_x_i;
      ey_q   <= end_y_i;
      show_q <= show_pixel_i;
    end
    if (fire) begin
      ctrl_q  <= ctrl_d;
      pix_x_q <= cur_x_d;
      pix_y_q <= cur_y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      tgt_x_q       <= '0;
      tgt_y_q       <= '0;
      tdx_q         <= '0;
      tdy_q         <= '0;
      err_q         <= '0;
      dxn_q         <= 1'b0;
      dyn_q         <= 1'b0;
      xmaj_q        <= 1'b0;
      show_line_q   <= 1'b0;
      line_active_q <= 1'b0;
    end else if (fire) begin
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      tgt_x_q       <= tgt_x_d;
      tgt_y_q       <= tgt_y_d;
      tdx_q         <= tdx_d;
      tdy_q         <= tdy_d;
      err_q         <= err_d;
      dxn_q         <= dxn_d;
      dyn_q         <= dyn_d;
      xmaj_q        <= xmaj_d;
      show_line_q   <= show_line_d;
      line_active_q <= line_active_d;
    end
  end

  assign pix_valid_o = pix_valid_q;
  assign pix_ctrl_o  = ctrl_q;
  assign pix_x_o     = pix_x_q;
  assign pix_y_o     = pix_y_q;

  `BLP_ASSERT(a_pix_hold, pix_valid_q && !pix_ready_i |=> pix_valid_q && $stable(pix_x_q) && $stable(pix_y_q) && $stable(ctrl_q), "pixel word changed while stalled")
  `BLP_ASSERT(a_major_span, line_active_q |-> (xmaj_q ? (tdx_q != '0) : (tdy_q != '0)), "active line has a zero major span")
  `BLP_ASSERT(a_last_idle, fire && ctrl_d.last |=> !line_active_q, "line stays active after its endpoint")

endmodule

>>> sv/blp_addr.sv
// Address stage: screen clipping, byte address and bit command, result register.
// Depends on blp_pkg.
module blp_addr #(
  parameter int COORD_BITS = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pix_valid_i,
  output logic                          pix_ready_o,
  input  blp_pkg::pix_ctrl_t            pix_ctrl_i,
  input  logic signed [COORD_BITS-1:0]  pix_x_i,
  input  logic signed [COORD_BITS-1:0]  pix_y_i,
  input  logic [blp_pkg::ADDR_W-1:0]    graphics_base_i,
  input  logic [blp_pkg::BPR_W-1:0]     bytes_per_row_i,
  input  logic [blp_pkg::SCREEN_W-1:0]  screen_width_i,
  input  logic [blp_pkg::SCREEN_W-1:0]  screen_height_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          pixel_valid_o,
  output logic signed [COORD_BITS-1:0]  pixel_x_o,
  output logic signed [COORD_BITS-1:0]  pixel_y_o,
  output logic                          on_screen_o,
  output logic [blp_pkg::ADDR_W-1:0]    byte_address_o,
  output logic [blp_pkg::CMD_W-1:0]     bit_command_o,
  output logic                          last_pixel_o
);
  import blp_pkg::*;

  localparam int CMP_W  = (COORD_BITS > SCREEN_W) ? COORD_BITS : SCREEN_W;
  localparam int PROD_W = COORD_BITS + BPR_W;

  logic                         out_valid_q;
  logic                         fire;
  logic [COORD_BITS-1:0]        x_u, y_u;
  logic                         on_d;
  logic [PROD_W-1:0]            row_off;
  logic [ADDR_W-1:0]            addr_d;
  logic [CMD_W-1:0]             cmd_d;
  logic [PIX_IDX_W-1:0]         bit_idx;

  logic                         pv_q, on_q, last_q;
  logic signed [COORD_BITS-1:0] x_q, y_q;
  logic [ADDR_W-1:0]            addr_q;
  logic [CMD_W-1:0]             cmd_q;

  assign pix_ready_o = !out_valid_q || !out_stall_i;
  assign fire        = pix_valid_i && pix_ready_o;

  assign x_u = pix_x_i;
  assign y_u = pix_y_i;

  assign on_d = pix_ctrl_i.line_pix && !pix_x_i[COORD_BITS-1] && !pix_y_i[COORD_BITS-1] &&
                (CMP_W'(x_u) < CMP_W'(screen_width_i)) &&
                (CMP_W'(y_u) < CMP_W'(screen_height_i));

  assign row_off = PROD_W'(y_u) * PROD_W'(bytes_per_row_i);
  assign bit_idx = PIX_IDX_W'(PIXELS_PER_BYTE - 1) - x_u[PIX_IDX_W-1:0];

  always_comb begin
    addr_d = '0;
    cmd_d  = '0;
    if (on_d) begin
      addr_d = graphics_base_i + ADDR_W'(row_off) + ADDR_W'(x_u >> PIX_IDX_W);
      cmd_d  = (pix_ctrl_i.show ? CMD_SET : CMD_CLEAR) | CMD_W'(bit_idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pix_ready_o) begin
      out_valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pv_q   <= pix_ctrl_i.line_pix;
      x_q    <= pix_ctrl_i.line_pix ? pix_x_i : '0;
      y_q    <= pix_ctrl_i.line_pix ? pix_y_i : '0;
      on_q   <= on_d;
      addr_q <= addr_d;
      cmd_q  <= cmd_d;
      last_q <= pix_ctrl_i.line_pix && pix_ctrl_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_valid_o  = pv_q;
  assign pixel_x_o      = x_q;
  assign pixel_y_o      = y_q;
  assign on_screen_o    = on_q;
  assign byte_address_o = addr_q;
  assign bit_command_o  = cmd_q;
  assign last_pixel_o   = last_q;

endmodule

>>> sv/bresenham_line_pixel_generator_unit.sv
// Line pixel generator: an accepted input word passes the input register and the step
// stage register to the address stage register, which holds its result word. One word
// per cycle is sustained unless stalled; the position and error update sets that cycle.
// Reset clears the line state and every stage valid and loads the register defaults.
// Top level: configuration registers and the two stages; depends on blp_pkg.
module bresenham_line_pixel_generator_unit #(
  parameter int COORD_BITS = 11
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [blp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [blp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  blp_pkg::req_e                   req_type_i,
  input  logic signed [COORD_BITS-1:0]    start_x_i,
  input  logic signed [COORD_BITS-1:0]    start_y_i,
  input  logic signed [COORD_BITS-1:0]    end_x_i,
  input  logic signed [COORD_BITS-1:0]    end_y_i,
  input  logic                            show_pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            pixel_valid_o,
  output logic signed [COORD_BITS-1:0]    pixel_x_o,
  output logic signed [COORD_BITS-1:0]    pixel_y_o,
  output logic                            on_screen_o,
  output logic [blp_pkg::ADDR_W-1:0]      byte_address_o,
  output logic [blp_pkg::CMD_W-1:0]       bit_command_o,
  output logic                            last_pixel_o
);
  import blp_pkg::*;

  logic [ADDR_W-1:0]   gbase_q, gbase_d;
  logic [BPR_W-1:0]    bpr_q, bpr_d;
  logic [SCREEN_W-1:0] swidth_q, swidth_d;
  logic [SCREEN_W-1:0] sheight_q, sheight_d;

  logic                         in_ready;
  logic                         pix_valid, pix_ready;
  pix_ctrl_t                    pix_ctrl;
  logic signed [COORD_BITS-1:0] pix_x, pix_y;

  always_comb begin
    gbase_d   = gbase_q;
    bpr_d     = bpr_q;
    swidth_d  = swidth_q;
    sheight_d = sheight_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GRAPHICS_BASE: gbase_d   = cfg_data_i;
        CFG_BYTES_PER_ROW: bpr_d     = cfg_data_i[BPR_W-1:0];
        CFG_SCREEN_WIDTH:  swidth_d  = cfg_data_i[SCREEN_W-1:0];
        CFG_SCREEN_HEIGHT: sheight_d = cfg_data_i[SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gbase_q   <= RST_GRAPHICS_BASE;
      bpr_q     <= RST_BYTES_PER_ROW;
      swidth_q  <= RST_SCREEN_WIDTH;
      sheight_q <= RST_SCREEN_HEIGHT;
    end else begin
      gbase_q   <= gbase_d;
      bpr_q     <= bpr_d;
      swidth_q  <= swidth_d;
      sheight_q <= sheight_d;
    end
  end

  assign in_stall_o = !in_ready;

  blp_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready),
    .req_type_i   (req_type_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .show_pixel_i (show_pixel_i),
    .pix_ready_i  (pix_ready),
    .pix_valid_o  (pix_valid),
    .pix_ctrl_o   (pix_ctrl),
    .pix_x_o      (pix_x),
    .pix_y_o      (pix_y)
  );

  blp_addr #(
    .COORD_BITS(COORD_BITS)
  ) u_addr (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pix_valid_i     (pix_valid),
    .pix_ready_o     (pix_ready),
    .pix_ctrl_i      (pix_ctrl),
    .pix_x_i         (pix_x),
    .pix_y_i         (pix_y),
    .graphics_base_i (gbase_q),
    .bytes_per_row_i (bpr_q),
    .screen_width_i  (swidth_q),
    .screen_height_i (sheight_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_valid_o   (pixel_valid_o),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .on_screen_o     (on_screen_o),
    .byte_address_o  (byte_address_o),
    .bit_command_o   (bit_command_o),
    .last_pixel_o    (last_pixel_o)
  );

endmodule

>>> test/tb_bresenham_line_pixel_generator_unit.sv
// Self-checking testbench for the Bresenham line pixel generator: directed lines, then
// random lines under several screen and memory settings, with random gaps and stalls.
// Depends on blp_pkg and bresenham_line_pixel_generator_unit.
module tb_bresenham_line_pixel_generator_unit;
  import blp_pkg::*;

  localparam int CW = 11;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd5;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 on_scr;
    logic [ADDR_W-1:0]    addr;
    logic [CMD_W-1:0]     cmd;
    logic                 is_last;
  } pixel_t;

  class line_scoreboard;
    logic [ADDR_W-1:0]   gfx_base;
    logic [BPR_W-1:0]    row_bytes;
    logic [SCREEN_W-1:0] width;
    logic [SCREEN_W-1:0] height;
    int cur_x, cur_y, end_x, end_y, span2_x, span2_y, err;
    bit neg_x, neg_y, x_major, show, active;
    pixel_t expected_q[$];
    int mismatches, checked, lines, on_seen, idle_seen;

    function new();
      gfx_base = RST_GRAPHICS_BASE;
      row_bytes = RST_BYTES_PER_ROW;
      width = RST_SCREEN_WIDTH;
      height = RST_SCREEN_HEIGHT;
      cur_x = 0; cur_y = 0; end_x = 0; end_y = 0;
      span2_x = 0; span2_y = 0; err = 0;
      neg_x = 0; neg_y = 0; x_major = 0; show = 0; active = 0;
      mismatches = 0; checked = 0; lines = 0; on_seen = 0; idle_seen = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRAPHICS_BASE: gfx_base = data[ADDR_W-1:0];
        CFG_BYTES_PER_ROW: row_bytes = data[BPR_W-1:0];
        CFG_SCREEN_WIDTH:  width = data[SCREEN_W-1:0];
        CFG_SCREEN_HEIGHT: height = data[SCREEN_W-1:0];
        default: ;
      endcase
    endfunction

    function pixel_t pixel_at(bit done);
      pixel_t p;
      int a;
      p = '0;
      p.valid = 1'b1;
      p.x = cur_x[CW-1:0];
      p.y = cur_y[CW-1:0];
      p.is_last = done;
      p.on_scr = cur_x >= 0 && cur_y >= 0 && cur_x < int'(width) && cur_y < int'(height);
      if (p.on_scr) begin
        a = int'(gfx_base) + cur_y * int'(row_bytes) + cur_x / PIXELS_PER_BYTE;
        p.addr = a[ADDR_W-1:0];
        p.cmd = (show ? CMD_SET : CMD_CLEAR) |
                CMD_W'(PIXELS_PER_BYTE - 1 - cur_x % PIXELS_PER_BYTE);
      end
      return p;
    endfunction

    function void note_input(req_e kind, logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                             logic signed [CW-1:0] ex, logic signed [CW-1:0] ey,
                             logic show_in);
      int dx, dy;
      bit done;
      if (kind == REQ_START) begin
        cur_x = sx; cur_y = sy; end_x = ex; end_y = ey;
        show = show_in;
        dx = end_x - cur_x;
        dy = end_y - cur_y;
        neg_x = dx < 0;
        neg_y = dy < 0;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        span2_x = 2 * dx;
        span2_y = 2 * dy;
        x_major = span2_x > span2_y;
        if (x_major) begin
          err = span2_y - span2_x / 2;
          done = cur_x == end_x;
        end else begin
          err = span2_x - span2_y / 2;
          done = cur_y == end_y;
        end
        lines++;
        active = !done;
        expected_q.push_back(pixel_at(done));
      end else if (!active) begin
        expected_q.push_back('0);
      end else begin
        if (x_major) begin
          if (err >= 0) begin
            cur_y += neg_y ? -1 : 1;
            err -= span2_x;
          end
          cur_x += neg_x ? -1 : 1;
          err += span2_y;
          done = cur_x == end_x;
        end else begin
          if (err >= 0) begin
            cur_x += neg_x ? -1 : 1;
            err -= span2_y;
          end
          cur_y += neg_y ? -1 : 1;
          err += span2_x;
          done = cur_y == end_y;
        end
        active = !done;
        expected_q.push_back(pixel_at(done));
      end
    endfunction

    function void check_result(pixel_t got);
      pixel_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: valid=%0d x=%0d y=%0d on=%0d addr=%h cmd=%h last=%0d",
                   got.valid, got.x, got.y, got.on_scr, got.addr, got.cmd, got.is_last);
      end else begin
        want = expected_q.pop_front();
        if (!want.valid) idle_seen++;
        if (want.on_scr) on_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("pixel mismatch: expected valid=%0d x=%0d y=%0d on=%0d addr=%h cmd=%h last=%0d",
                     want.valid, want.x, want.y, want.on_scr, want.addr, want.cmd, want.is_last);
            $display("                actual   valid=%0d x=%0d y=%0d on=%0d addr=%h cmd=%h last=%0d",
                     got.valid, got.x, got.y, got.on_scr, got.addr, got.cmd, got.is_last);
          end
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  req_e                  req_type_i;
  logic signed [CW-1:0]  start_x_i, start_y_i, end_x_i, end_y_i;
  logic                  show_pixel_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  pixel_valid_o;
  logic signed [CW-1:0]  pixel_x_o, pixel_y_o;
  logic                  on_screen_o;
  logic [ADDR_W-1:0]     byte_address_o;
  logic [CMD_W-1:0]      bit_command_o;
  logic                  last_pixel_o;

  line_scoreboard sb = new();
  pixel_t seen;
  logic [9:0] stall_cyc = '0;
  int quiet_cycles = 0;
  int words_sent;
  int burst_left;
  int settings_used;

  bresenham_line_pixel_generator_unit #(.COORD_BITS(CW)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .req_type_i(req_type_i),
    .start_x_i(start_x_i), .start_y_i(start_y_i), .end_x_i(end_x_i), .end_y_i(end_y_i),
    .show_pixel_i(show_pixel_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .pixel_valid_o(pixel_valid_o), .pixel_x_o(pixel_x_o), .pixel_y_o(pixel_y_o),
    .on_screen_o(on_screen_o), .byte_address_o(byte_address_o),
    .bit_command_o(bit_command_o), .last_pixel_o(last_pixel_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_input(req_type_i, start_x_i, start_y_i, end_x_i, end_y_i, show_pixel_i);
      if (out_valid_o && !out_stall_i) begin
        seen.valid = pixel_valid_o;
        seen.x = pixel_x_o;
        seen.y = pixel_y_o;
        seen.on_scr = on_screen_o;
        seen.addr = byte_address_o;
        seen.cmd = bit_command_o;
        seen.is_last = last_pixel_o;
        sb.check_result(seen);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("[bresenham_line_pixel_generator_unit] ERROR");
        $finish;
      end
    end
    stall_cyc = stall_cyc + 10'd1;
    case (stall_cyc[9:8])
      2'd0: out_stall_i <= 1'b0;
      2'd1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall_i <= stall_cyc[4] & stall_cyc[2];
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic logic signed [CW-1:0] to_coord(int v);
    if (v > 1023) v = 1023;
    if (v < -1024) v = -1024;
    return v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] any_coord();
    return CW'($urandom_range(0, 2047));
  endfunction

  function automatic logic signed [CW-1:0] pick_coord(int extent);
    case ($urandom_range(0, 9))
      0: return any_coord();
      1: return $urandom_range(0, 1) ? to_coord(1023) : to_coord(-1024);
      default: return to_coord(int'($urandom_range(0, extent + 16)) - 8);
    endcase
  endfunction

  function automatic int pick_span();
    if ($urandom_range(0, 9) == 0)
      return int'($urandom_range(0, 400)) - 200;
    return int'($urandom_range(0, 60)) - 30;
  endfunction

  task automatic send_word(req_e kind, logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                           logic signed [CW-1:0] ex, logic signed [CW-1:0] ey, logic show);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    start_x_i <= sx;
    start_y_i <= sy;
    end_x_i <= ex;
    end_y_i <= ey;
    show_pixel_i <= show;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_step();
    send_word(REQ_STEP, any_coord(), any_coord(), any_coord(), any_coord(),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_line();
    logic signed [CW-1:0] sx, sy, ex, ey;
    int dx, dy, steps;
    sx = pick_coord(int'(sb.width));
    sy = pick_coord(int'(sb.height));
    ex = to_coord(int'(sx) + pick_span());
    ey = to_coord(int'(sy) + pick_span());
    dx = int'(ex) - int'(sx);
    dy = int'(ey) - int'(sy);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    steps = (dx > dy) ? dx : dy;
    case ($urandom_range(0, 7))
      0: steps = $urandom_range(0, steps);
      1: steps += $urandom_range(1, 3);
      default: ;
    endcase
    send_word(REQ_START, sx, sy, ex, ey, 1'($urandom_range(0, 1)));
    repeat (steps) send_step();
  endtask

  task automatic run_random(int count);
    int goal;
    goal = words_sent + count;
    while (words_sent < goal) begin
      if ($urandom_range(0, 9) == 0)
        send_word(req_e'($urandom_range(0, 1)), any_coord(), any_coord(), any_coord(),
                  any_coord(), 1'($urandom_range(0, 1)));
      else
        send_line();
    end
  endtask

  task automatic send_directed_line(int sx, int sy, int ex, int ey, logic show, int steps);
    send_word(REQ_START, to_coord(sx), to_coord(sy), to_coord(ex), to_coord(ey), show);
    repeat (steps) send_step();
  endtask

  task automatic run_directed();
    send_step();
    send_directed_line(5, 5, 5, 5, 1'b1, 1);
    send_directed_line(0, 0, 5, 2, 1'b1, 5);
    send_directed_line(-2, -1, 1, 4, 1'b0, 5);
    send_directed_line(10, 10, 7, 7, 1'b1, 3);
    send_directed_line(-1024, 1023, 1023, -1024, 1'b1, 2);
    send_directed_line(239, 127, 240, 128, 1'b0, 1);
    send_directed_line(1023, 1023, -1024, -1024, 1'b1, 1);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_register(idx, data);
  endtask

  task automatic set_screen(logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] bpr,
                            logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    wait_for_results();
    cfg_write(CFG_GRAPHICS_BASE, base);
    cfg_write(CFG_BYTES_PER_ROW, bpr);
    cfg_write(CFG_SCREEN_WIDTH, w);
    cfg_write(CFG_SCREEN_HEIGHT, h);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    req_type_i <= REQ_START;
    start_x_i <= '0;
    start_y_i <= '0;
    end_x_i <= '0;
    end_y_i <= '0;
    show_pixel_i <= 1'b0;
    words_sent = 0;
    burst_left = 0;
    settings_used = 1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(120);

    set_screen(16'($urandom), 16'd255, 16'd1023, 16'd1023);
    run_random(140);
    set_screen(16'hFFFF, 16'd128, 16'd1, 16'd1);
    run_random(120);
    set_screen(16'($urandom), {8'($urandom), 8'($urandom_range(1, 128))},
               {6'($urandom), 10'($urandom_range(1, 1023))},
               {6'($urandom), 10'($urandom_range(1, 1023))});
    run_random(140);
    set_screen(16'($urandom), 16'd0, 16'($urandom_range(1, 1023)),
               16'($urandom_range(1, 1023)));
    cfg_write(CFG_SPARE_IDX, 16'h0003);
    cfg_we_i <= 1'b0;
    run_random(140);
    set_screen(16'($urandom), 16'($urandom_range(1, 128)), 16'd0,
               16'($urandom_range(1, 1023)));
    run_random(60);
    set_screen(16'(RST_GRAPHICS_BASE), 16'(RST_BYTES_PER_ROW), 16'(RST_SCREEN_WIDTH),
               16'(RST_SCREEN_HEIGHT));
    run_random(130);

    wait_for_results();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d words (%0d line starts) under %0d register settings.",
             words_sent, sb.lines, settings_used);
    $display("Checked %0d pixel words: %0d on screen, %0d idle steps, %0d mismatches.",
             sb.checked, sb.on_seen, sb.idle_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("[bresenham_line_pixel_generator_unit] OK");
    else
      $display("[bresenham_line_pixel_generator_unit] ERROR");
    $finish;
  end
endmodule
